// File: rtl/srrc_pkg.sv
// shared types, constants and helpers for the spsc ring reserve/commit pointer controller
package srrc_pkg;

   // field widths of the request and response transfers
   localparam int ACTION_W   = 3;
   localparam int LENGTH_W   = 13;
   localparam int STATUS_W   = 2;
   localparam int OFFSET_W   = 12;
   localparam int COUNT_W    = 13;
   localparam int THRESH_W   = 13;

   // request tdata: action, length
   localparam int REQ_DATA_W = 16;
   // response fields packed, then padded to whole bytes
   localparam int RSP_FIELDS_W = STATUS_W + OFFSET_W + 1 + COUNT_W + COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // ring size limits and batch threshold default
   localparam int CAPACITY_DEFAULT = 4096;
   localparam int CAPACITY_LIMIT   = 1048576;
   localparam int THRESH_PERCENT   = 5;
   localparam int PERCENT_SCALE    = 100;

   typedef enum logic [ACTION_W-1:0] {
      ACT_RESERVE_WRITE = 3'd0,
      ACT_ADVANCE_WRITE = 3'd1,
      ACT_PUBLISH_WRITE = 3'd2,
      ACT_RESERVE_READ  = 3'd3,
      ACT_ADVANCE_READ  = 3'd4,
      ACT_PUBLISH_READ  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_UNAVAILABLE = 2'd1,
      ST_REFUSED     = 2'd2
   } status_type;

   // one response, last member in the lowest bits
   typedef struct packed {
      logic [COUNT_W-1:0]  unread_bytes;
      logic [COUNT_W-1:0]  free_bytes;
      logic                is_empty;
      logic [OFFSET_W-1:0] offset;
      status_type          status;
   } result_type;

   // round the requested size up to a power of two, capped at the limit
   function automatic int ring_cap(input int requested);
      int c;
      c = 1;
      while (c < requested && c < CAPACITY_LIMIT) begin
         c = c * 2;
      end
      return c;
   endfunction

endpackage

// File: rtl/srrc_step.sv
// next-state and response logic for one ring action
module srrc_step #(
   parameter int CAPACITY_BYTES = srrc_pkg::CAPACITY_DEFAULT,
   parameter int PW             = $clog2(srrc_pkg::ring_cap(CAPACITY_BYTES)) + 1
) (
   input  srrc_pkg::action_type              action,
   input  logic [srrc_pkg::LENGTH_W-1:0]     length,
   input  logic [srrc_pkg::THRESH_W-1:0]     batch_threshold,
   input  logic [PW-1:0]                     wr_pos,
   input  logic [PW-1:0]                     wr_pub_pos,
   input  logic [PW-1:0]                     rd_pos,
   input  logic [PW-1:0]                     rd_pub_pos,
   output logic [PW-1:0]                     wr_pos_next,
   output logic [PW-1:0]                     wr_pub_pos_next,
   output logic [PW-1:0]                     rd_pos_next,
   output logic [PW-1:0]                     rd_pub_pos_next,
   output srrc_pkg::result_type              result
);
   import srrc_pkg::*;

   localparam int CAP = ring_cap(CAPACITY_BYTES);
   localparam int CW  = (PW > LENGTH_W) ? PW : LENGTH_W;
   localparam logic [PW-1:0] CAP_POS = PW'(CAP);

   // space left for the writer, given its position and the published reader
   function automatic logic [PW-1:0] free_of(input logic [PW-1:0] w, input logic [PW-1:0] p);
      logic [PW-1:0] gap;
      gap = w - p;
      return (gap > CAP_POS) ? '0 : (CAP_POS - gap);
   endfunction

   logic [PW-1:0] free_cur;
   logic [PW-1:0] unread_cur;
   logic [PW-1:0] rd_unpub;
   logic [CW-1:0] len_ext;
   logic [PW-1:0] len_pos;
   logic [PW-1:0] free_new;
   logic [PW-1:0] unread_new;
   status_type    status;
   logic [OFFSET_W-1:0] offset;

   // figures before the action
   assign free_cur   = free_of(wr_pos, rd_pub_pos);
   assign unread_cur = wr_pub_pos - rd_pos;
   assign rd_unpub   = rd_pos - rd_pub_pos;
   assign len_ext    = CW'(length);
   assign len_pos    = PW'(length);

   // action decode and position updates
   always_comb begin
      wr_pos_next     = wr_pos;
      wr_pub_pos_next = wr_pub_pos;
      rd_pos_next     = rd_pos;
      rd_pub_pos_next = rd_pub_pos;
      status          = ST_OK;
      offset          = '0;
      case (action)
         ACT_RESERVE_WRITE: begin
            if (len_ext <= CW'(free_cur)) begin
               offset = OFFSET_W'(wr_pos[PW-2:0]);
            end else begin
               status = ST_UNAVAILABLE;
            end
         end
         ACT_ADVANCE_WRITE: begin
            if (len_ext > CW'(free_cur)) begin
               status = ST_REFUSED;
            end else begin
               wr_pos_next = wr_pos + len_pos;
            end
         end
         ACT_PUBLISH_WRITE: begin
            wr_pub_pos_next = wr_pos;
         end
         ACT_RESERVE_READ: begin
            if (wr_pub_pos != rd_pos) begin
               offset = OFFSET_W'(rd_pos[PW-2:0]);
            end else begin
               status = ST_UNAVAILABLE;
            end
         end
         ACT_ADVANCE_READ: begin
            if (len_ext > CW'(unread_cur)) begin
               status = ST_REFUSED;
            end else begin
               rd_pos_next = rd_pos + len_pos;
            end
         end
         ACT_PUBLISH_READ: begin
            // reader publishes only in batches
            if (CW'(rd_unpub) >= CW'(batch_threshold)) begin
               rd_pub_pos_next = rd_pos;
            end
         end
         default: begin
         end
      endcase
   end

   // figures after the action
   assign free_new   = free_of(wr_pos_next, rd_pub_pos_next);
   assign unread_new = wr_pub_pos_next - rd_pos_next;

   assign result.status       = status;
   assign result.offset       = offset;
   assign result.is_empty     = (rd_pos_next == wr_pub_pos_next);
   assign result.free_bytes   = COUNT_W'(free_new);
   assign result.unread_bytes = COUNT_W'(unread_new);

endmodule

// File: rtl/spsc_ring_reserve_commit.sv
// top level: pointer controller for a single-producer single-consumer byte ring
//
// Takes one action per request transfer and returns exactly one response per action, in
// order. Throughput is one action per clock cycle while the response side is not stalled:
// each action is held in an input register, evaluated by the pointer update logic and
// written to the response register, which presents it on the response port until it is
// transferred. The response register lets a new request be taken while a finished response
// still waits. Ring capacity is CAPACITY_BYTES rounded up to a power of two (at most 1 MiB);
// positions wrap at twice that size. The batch threshold resets to 5 percent of the capacity
// and may be rewritten through the csr port while no action is in flight.
module spsc_ring_reserve_commit #(
   parameter int CAPACITY_BYTES = srrc_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: action [2:0], length [15:3]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [srrc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response: status [1:0], offset [13:2], is_empty [14], free_bytes [27:15],
   // unread_bytes [40:28], zero pad [47:41]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [srrc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // batch threshold write
   input  logic                               csr_wr_en,
   input  logic [srrc_pkg::THRESH_W-1:0]      csr_wr_data
);
   import srrc_pkg::*;

   localparam int CAP = ring_cap(CAPACITY_BYTES);
   localparam int PW  = $clog2(CAP) + 1;
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'((CAP * THRESH_PERCENT) / PERCENT_SCALE);

   logic                in_valid_ff, in_valid_in;
   action_type          in_action_ff;
   logic [LENGTH_W-1:0] in_length_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [PW-1:0]       wr_pos_ff, wr_pub_pos_ff, rd_pos_ff, rd_pub_pos_ff;
   logic [PW-1:0]       wr_pos_in, wr_pub_pos_in, rd_pos_in, rd_pub_pos_in;
   result_type          step_result;
   logic                req_xfer;
   logic                step_fire;

   // the held action executes when the response register is free or being emptied
   assign step_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !step_fire);
   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_tready);

   // pointer update logic
   srrc_step #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .PW             (PW)
   ) u_step (
      .action          (in_action_ff),
      .length          (in_length_ff),
      .batch_threshold (thresh_ff),
      .wr_pos          (wr_pos_ff),
      .wr_pub_pos      (wr_pub_pos_ff),
      .rd_pos          (rd_pos_ff),
      .rd_pub_pos      (rd_pub_pos_ff),
      .wr_pos_next     (wr_pos_in),
      .wr_pub_pos_next (wr_pub_pos_in),
      .rd_pos_next     (rd_pos_in),
      .rd_pub_pos_next (rd_pub_pos_in),
      .result          (step_result)
   );

   // control and ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thresh_ff     <= THRESH_RESET;
         wr_pos_ff     <= '0;
         wr_pub_pos_ff <= '0;
         rd_pos_ff     <= '0;
         rd_pub_pos_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (step_fire) begin
            wr_pos_ff     <= wr_pos_in;
            wr_pub_pos_ff <= wr_pub_pos_in;
            rd_pos_ff     <= rd_pos_in;
            rd_pub_pos_ff <= rd_pub_pos_in;
         end
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_action_ff <= action_type'(req_tdata[ACTION_W-1:0]);
         in_length_ff <= req_tdata[ACTION_W +: LENGTH_W];
      end
      if (step_fire) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

`ifndef SYNTH
   logic [PW-1:0] wr_gap;
   assign wr_gap = wr_pos_ff - rd_pub_pos_ff;

   // writer never runs more than one ring ahead of the published reader
   a_gap_bounded: assert property (@(posedge clock) disable iff (reset)
      !(wr_gap > PW'(CAP)))
      else $error("write gap exceeds capacity");

   // a refused advance leaves every position untouched
   a_refused_no_move: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_result.status == ST_REFUSED |=>
         $stable(wr_pos_ff) && $stable(rd_pos_ff) &&
         $stable(wr_pub_pos_ff) && $stable(rd_pub_pos_ff))
      else $error("refused advance changed ring state");

   // published write position moves only on a publish write
   a_wr_pub_only_on_publish: assert property (@(posedge clock) disable iff (reset)
      !(step_fire && in_action_ff == ACT_PUBLISH_WRITE) |=> $stable(wr_pub_pos_ff))
      else $error("published write position moved without publish");

   // a held action stays put until it executes
   a_held_action: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_fire |=>
         in_valid_ff && $stable(in_action_ff) && $stable(in_length_ff))
      else $error("held action lost or changed");
`endif

endmodule

// File: verif/spsc_ring_reserve_commit_tb.sv
// self-checking testbench for the spsc ring reserve/commit pointer controller
`timescale 1ns / 100ps

module spsc_ring_reserve_commit_tb;
   import srrc_pkg::*;

   localparam int RING_BYTES  = 4096;
   localparam int MAX_LEN     = 4096;
   localparam int CYCLE_LIMIT = 100000;
   localparam int SHOWN_LIMIT = 10;
   localparam int HOLD_AFTER  = 500;
   localparam int HOLD_CYCLES = 300;

   // ring pointer predictor and queue of predicted responses
   class ring_pointer_scoreboard;
      logic [COUNT_W-1:0]  wr_pos;
      logic [COUNT_W-1:0]  wr_pub;
      logic [COUNT_W-1:0]  rd_pos;
      logic [COUNT_W-1:0]  rd_pub;
      logic [THRESH_W-1:0] threshold;
      result_type          pending_results[$];
      int                  mismatches;

      function new();
         wr_pos     = '0;
         wr_pub     = '0;
         rd_pos     = '0;
         rd_pub     = '0;
         threshold  = THRESH_W'(RING_BYTES * THRESH_PERCENT / PERCENT_SCALE);
         mismatches = 0;
      endfunction

      function void set_threshold(logic [THRESH_W-1:0] value);
         threshold = value;
      endfunction

      function logic [COUNT_W-1:0] free_bytes();
         logic [COUNT_W-1:0] gap;
         gap = wr_pos - rd_pub;
         return (gap > RING_BYTES) ? '0 : COUNT_W'(RING_BYTES - gap);
      endfunction

      function logic [COUNT_W-1:0] unread_bytes();
         return wr_pub - rd_pos;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // advance the pointer state by one accepted action and queue its response
      function void apply_action(logic [ACTION_W-1:0] act, logic [LENGTH_W-1:0] len);
         result_type         r;
         logic [COUNT_W-1:0] lag;
         r = '0;
         r.status = ST_OK;
         case (act)
            ACT_RESERVE_WRITE: begin
               if (len <= free_bytes()) r.offset = wr_pos[OFFSET_W-1:0];
               else r.status = ST_UNAVAILABLE;
            end
            ACT_ADVANCE_WRITE: begin
               if (len > free_bytes()) r.status = ST_REFUSED;
               else wr_pos = wr_pos + len;
            end
            ACT_PUBLISH_WRITE: wr_pub = wr_pos;
            ACT_RESERVE_READ: begin
               if (wr_pub != rd_pos) r.offset = rd_pos[OFFSET_W-1:0];
               else r.status = ST_UNAVAILABLE;
            end
            ACT_ADVANCE_READ: begin
               if (len > unread_bytes()) r.status = ST_REFUSED;
               else rd_pos = rd_pos + len;
            end
            ACT_PUBLISH_READ: begin
               lag = rd_pos - rd_pub;
               if (lag >= threshold) rd_pub = rd_pos;
            end
            default: ;
         endcase
         r.is_empty     = (rd_pos == wr_pub);
         r.free_bytes   = free_bytes();
         r.unread_bytes = unread_bytes();
         pending_results.push_back(r);
      endfunction

      // compare one response transfer with the oldest prediction
      function void check_result(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type want;
         got = result_type'(data[RSP_FIELDS_W-1:0]);
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT)
               $display("unexpected response: status %0d offset %0d", got.status, got.offset);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.offset !== want.offset ||
             got.is_empty !== want.is_empty || got.free_bytes !== want.free_bytes ||
             got.unread_bytes !== want.unread_bytes) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT)
               $display("mismatch: expected st %0d off %0d empty %0d free %0d unread %0d, %s",
                        want.status, want.offset, want.is_empty, want.free_bytes,
                        want.unread_bytes,
                        $sformatf("got st %0d off %0d empty %0d free %0d unread %0d",
                                  got.status, got.offset, got.is_empty, got.free_bytes,
                                  got.unread_bytes));
         end
      endfunction

      function int failures();
         return mismatches + pending_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [THRESH_W-1:0]   csr_wr_data;

   ring_pointer_scoreboard sb;
   bit                     calm = 1'b0;
   int                     rsp_seen = 0;
   int                     hold_left = 0;
   bit                     hold_done = 1'b0;
   int                     cycle_count = 0;
   logic [ACTION_W-1:0]    plan_act[$];
   logic [LENGTH_W-1:0]    plan_len[$];

   spsc_ring_reserve_commit #(
      .CAPACITY_BYTES(RING_BYTES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         rsp_seen <= rsp_seen + 1;
      end
   end

   function automatic int unsigned clip(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   // offer one action, note it in the predictor on transfer; starts and ends at a falling edge
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [LENGTH_W-1:0] len);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, act};
      do @(posedge clock); while (!req_tready);
      sb.apply_action(act, len);
      @(negedge clock);
   endtask

   // rewrite the batch threshold once all responses are back
   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_threshold(value);
   endtask

   // queue a writer or reader sequence built from the current pointers, or a stray action
   task automatic plan_sequence();
      int unsigned room;
      int unsigned resv;
      int unsigned adv;
      int unsigned avail;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         plan_act.push_back(ACTION_W'($urandom_range(0, 7)));
         plan_len.push_back(LENGTH_W'($urandom_range(0, MAX_LEN)));
      end else if (pick < 58) begin
         // writer: reserve, advance, and usually publish
         room = sb.free_bytes();
         pick = $urandom_range(0, 99);
         if (pick < 25) resv = room;
         else if (pick < 45) resv = $urandom_range(0, clip(room, 32));
         else resv = $urandom_range(0, room);
         plan_act.push_back(ACT_RESERVE_WRITE);
         plan_len.push_back(LENGTH_W'(resv));
         pick = $urandom_range(0, 99);
         if (pick < 70) adv = resv;
         else if (pick < 90) adv = $urandom_range(0, resv);
         else adv = clip(room + 1, MAX_LEN);
         plan_act.push_back(ACT_ADVANCE_WRITE);
         plan_len.push_back(LENGTH_W'(adv));
         if ($urandom_range(0, 9) != 0) begin
            plan_act.push_back(ACT_PUBLISH_WRITE);
            plan_len.push_back(LENGTH_W'($urandom_range(0, MAX_LEN)));
         end
      end else begin
         // reader: reserve, advance, and usually publish
         avail = sb.unread_bytes();
         plan_act.push_back(ACT_RESERVE_READ);
         plan_len.push_back(LENGTH_W'($urandom_range(0, MAX_LEN)));
         pick = $urandom_range(0, 99);
         if (pick < 30) adv = avail;
         else if (pick < 60) adv = $urandom_range(0, clip(avail, 32));
         else if (pick < 92) adv = $urandom_range(0, avail);
         else adv = clip(avail + 1, MAX_LEN);
         plan_act.push_back(ACT_ADVANCE_READ);
         plan_len.push_back(LENGTH_W'(adv));
         if ($urandom_range(0, 9) != 0) begin
            plan_act.push_back(ACT_PUBLISH_READ);
            plan_len.push_back(LENGTH_W'($urandom_range(0, MAX_LEN)));
         end
      end
   endtask

   task automatic run_random(input int count);
      logic [ACTION_W-1:0] act;
      logic [LENGTH_W-1:0] len;
      for (int i = 0; i < count; i++) begin
         if (plan_act.size() == 0) plan_sequence();
         act = plan_act.pop_front();
         len = plan_len.pop_front();
         send_item(act, len);
      end
   endtask

   // directed corners: empty ring, full ring, refusals, threshold, unused codes
   task automatic run_directed();
      send_item(ACT_RESERVE_READ, 0);        // nothing published yet
      send_item(ACT_ADVANCE_READ, 1);        // read past published data
      send_item(ACT_PUBLISH_READ, 0);        // below threshold
      send_item(ACT_RESERVE_WRITE, 0);
      send_item(ACT_RESERVE_WRITE, MAX_LEN);
      send_item(ACT_ADVANCE_WRITE, MAX_LEN); // ring now full
      send_item(ACT_RESERVE_WRITE, 1);       // no space
      send_item(ACT_RESERVE_WRITE, 0);       // zero length still succeeds
      send_item(ACT_ADVANCE_WRITE, 1);       // advance past free space
      send_item(ACT_RESERVE_READ, 0);        // written but not published
      send_item(ACT_PUBLISH_WRITE, 0);
      send_item(ACT_RESERVE_READ, 0);
      send_item(ACT_ADVANCE_READ, MAX_LEN);
      send_item(ACT_PUBLISH_READ, 0);        // full ring read, above threshold
      send_item(3'd6, MAX_LEN);              // unused codes
      send_item(3'd7, 2730);
      send_item(ACT_ADVANCE_WRITE, 100);
      send_item(ACT_PUBLISH_WRITE, 5461 % 8192 & 4095);
      send_item(ACT_ADVANCE_READ, 50);
      send_item(ACT_PUBLISH_READ, 0);        // small advance stays private
      send_item(ACT_RESERVE_READ, 1365);
      send_item(ACT_RESERVE_WRITE, MAX_LEN); // reader gap limits space
      send_item(ACT_ADVANCE_WRITE, 3996);
      send_item(ACT_RESERVE_WRITE, 0);
   endtask

   initial begin
      logic [THRESH_W-1:0] settings[6];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      sb          = new();
      settings[0] = 0;
      settings[1] = 1;
      settings[2] = MAX_LEN;
      settings[3] = MAX_LEN - 1;
      settings[4] = THRESH_W'($urandom_range(0, MAX_LEN));
      settings[5] = THRESH_W'(RING_BYTES * THRESH_PERCENT / PERCENT_SCALE);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(220);
      for (int k = 0; k < 6; k++) begin
         write_threshold(settings[k]);
         calm = (k == 2);
         run_random(205);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain and let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/srrc_pkg.sv
rtl/srrc_step.sv
rtl/spsc_ring_reserve_commit.sv
verif/spsc_ring_reserve_commit_tb.sv
